// ----- src/sorted_table_binary_search_core_assert.svh -----
// Assertion macros for the sorted table core.
// Included by the top level; needs nothing else.
`ifndef SORTED_TABLE_BINARY_SEARCH_CORE_ASSERT_SVH
`define SORTED_TABLE_BINARY_SEARCH_CORE_ASSERT_SVH

// same-cycle implication
`define STBS_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");

// next-cycle implication
`define STBS_ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");

`endif

// ----- src/stbs_pkg.sv -----
// Package of the sorted table core: sizes, codes and transaction types.
// No dependencies.
`default_nettype none
package stbs_pkg;
  localparam int DEPTH       = 64;
  localparam int KEY_WIDTH   = 32;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int SW          = IDX_W + 2;

  typedef logic signed [SW-1:0] sidx_t;

  typedef enum logic [1:0] {
    OP_SEARCH = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] key;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] found_value;
    logic [6:0]  entry_count;
  } rsp_t;

  typedef struct packed {
    logic [KEY_WIDTH-1:0]   key;
    logic [VALUE_WIDTH-1:0] value;
  } entry_t;

  typedef struct packed {
    logic             shift_up;
    logic             shift_dn;
    logic [IDX_W-1:0] pos;
    entry_t           ins;
  } cell_ctrl_t;
endpackage
`default_nettype wire

// ----- src/sorted_table_binary_search_core.sv -----
// Sorted key/value table: a row of slot cells with a binary-search sequencer.
// Depends on stbs_pkg, stbs_cell and the assertion macro header.
//
// A transaction is taken when start is high and busy is low. Each probe of the
// binary search steps through the midpoint, slot read and compare states, and the
// insert/delete move is a single shift of the slots from the insert or delete
// position upward. No-op and full-table inserts are answered from the idle
// state with no search. The result appears on rsp_o for exactly
// one cycle with done_o high and cannot be held off by the receiver.
`default_nettype none
`include "sorted_table_binary_search_core_assert.svh"
module sorted_table_binary_search_core (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire stbs_pkg::req_t req_i,
  output logic                done_o,
  output stbs_pkg::rsp_t      rsp_o
);
  import stbs_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_MID, S_RD, S_CMP, S_END, S_SHIFT} state_e;

  state_e             state_q;
  logic [1:0]         op_q;
  entry_t             req_ent_q;
  logic [CNT_W-1:0]   count_q;
  sidx_t              lo_q, hi_q;
  logic [IDX_W-1:0]   mid_q, pos_q;
  logic               hit_q;
  entry_t             rd_q;
  sidx_t              sum;
  cell_ctrl_t         ctrl;
  entry_t             ent [DEPTH];

  assign sum = lo_q + hi_q;

  assign ctrl.shift_up = (state_q == S_SHIFT) && (op_q == OP_INSERT);
  assign ctrl.shift_dn = (state_q == S_SHIFT) && (op_q == OP_DELETE);
  assign ctrl.pos      = pos_q;
  assign ctrl.ins      = req_ent_q;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t below, above;
    if (i == 0) begin : g_lo
      assign below = ent[0];
    end else begin : g_lo
      assign below = ent[i-1];
    end
    if (i == DEPTH - 1) begin : g_hi
      assign above = ent[i];
    end else begin : g_hi
      assign above = ent[i+1];
    end
    stbs_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .idx_i   (IDX_W'(i)),
      .below_i (below),
      .above_i (above),
      .ent_o   (ent[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_RD) rd_q <= ent[mid_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      done_o    <= 1'b0;
      op_q      <= '0;
      req_ent_q <= '0;
      lo_q      <= '0;
      hi_q      <= '0;
      mid_q     <= '0;
      pos_q     <= '0;
      hit_q     <= 1'b0;
      rsp_o     <= '0;
    end else begin
      done_o <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            op_q      <= req_i.op;
            req_ent_q <= '{key: req_i.key[KEY_WIDTH-1:0], value: req_i.value[VALUE_WIDTH-1:0]};
            lo_q      <= '0;
            hi_q      <= sidx_t'({1'b0, count_q}) - sidx_t'(1);
            hit_q     <= 1'b0;
            pos_q     <= '0;
            if (req_i.op == OP_NONE) begin
              done_o <= 1'b1;
              rsp_o  <= '{status: ST_OK, found_value: '0, entry_count: 7'(count_q)};
            end else if (req_i.op == OP_INSERT && count_q == CNT_W'(DEPTH)) begin
              done_o <= 1'b1;
              rsp_o  <= '{status: ST_FULL, found_value: '0, entry_count: 7'(count_q)};
            end else if (req_i.op == OP_INSERT && count_q == '0) begin
              state_q <= S_SHIFT;
            end else begin
              state_q <= S_MID;
            end
          end
        end
        S_MID: begin
          if (lo_q <= hi_q) begin
            mid_q   <= sum[IDX_W:1];
            state_q <= S_RD;
          end else begin
            state_q <= S_END;
          end
        end
        S_RD: state_q <= S_CMP;
        S_CMP: begin
          if (rd_q.key == req_ent_q.key) begin
            hit_q   <= 1'b1;
            state_q <= S_END;
          end else begin
            if (rd_q.key < req_ent_q.key) lo_q <= sidx_t'({2'b00, mid_q}) + sidx_t'(1);
            else hi_q <= sidx_t'({2'b00, mid_q}) - sidx_t'(1);
            state_q <= S_MID;
          end
        end
        S_END: begin
          case (op_q)
            OP_INSERT: begin
              pos_q   <= (rd_q.key > req_ent_q.key) ? mid_q : mid_q + IDX_W'(1);
              state_q <= S_SHIFT;
            end
            OP_DELETE: begin
              pos_q <= mid_q;
              if (hit_q) begin
                state_q <= S_SHIFT;
              end else begin
                done_o  <= 1'b1;
                rsp_o   <= '{status: ST_NOT_FOUND, found_value: '0,
                             entry_count: 7'(count_q)};
                state_q <= S_IDLE;
              end
            end
            default: begin
              done_o  <= 1'b1;
              rsp_o   <= '{status: hit_q ? ST_OK : ST_NOT_FOUND,
                           found_value: hit_q ? 32'(rd_q.value) : '0,
                           entry_count: 7'(count_q)};
              state_q <= S_IDLE;
            end
          endcase
        end
        S_SHIFT: begin
          done_o <= 1'b1;
          if (op_q == OP_INSERT) begin
            count_q <= count_q + CNT_W'(1);
            rsp_o   <= '{status: ST_OK, found_value: '0, entry_count: 7'(count_q + CNT_W'(1))};
          end else begin
            count_q <= count_q - CNT_W'(1);
            rsp_o   <= '{status: ST_OK, found_value: '0, entry_count: 7'(count_q - CNT_W'(1))};
          end
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy = (state_q != S_IDLE);

  `STBS_ASSERT_IMP(a_done_idle, clk_i, rst_ni, done_o, !busy)
  `STBS_ASSERT_NXT(a_start_busy, clk_i, rst_ni, start && !busy && req_i.op != OP_NONE && !(req_i.op == OP_INSERT && count_q == CNT_W'(DEPTH)), busy)
  `STBS_ASSERT_IMP(a_full_count, clk_i, rst_ni, done_o && rsp_o.status == ST_FULL, rsp_o.entry_count == 7'(DEPTH))
  `STBS_ASSERT_IMP(a_count_max, clk_i, rst_ni, 1'b1, count_q <= CNT_W'(DEPTH))
endmodule
`default_nettype wire

// ----- src/stbs_cell.sv -----
// One table slot: holds an entry, takes a neighbor's entry on a shift or loads an insert.
// Depends on stbs_pkg.
`default_nettype none
module stbs_cell (
  input  wire logic                      clk_i,
  input  wire stbs_pkg::cell_ctrl_t      ctrl_i,
  input  wire logic [stbs_pkg::IDX_W-1:0] idx_i,
  input  wire stbs_pkg::entry_t          below_i,
  input  wire stbs_pkg::entry_t          above_i,
  output stbs_pkg::entry_t               ent_o
);
  import stbs_pkg::*;

  entry_t ent_q, ent_d;

  always_comb begin
    ent_d = ent_q;
    if (ctrl_i.shift_up) begin
      if (idx_i > ctrl_i.pos) ent_d = below_i;
      else if (idx_i == ctrl_i.pos) ent_d = ctrl_i.ins;
    end else if (ctrl_i.shift_dn) begin
      if (idx_i >= ctrl_i.pos) ent_d = above_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;
endmodule
`default_nettype wire

// ----- dv/tb.sv -----
// Self-checking bench for sorted_table_binary_search_core: search, insert,
// delete and no-op requests checked by a behavioral sorted-table predictor.
// Depends on stbs_pkg and the core RTL.
module tb;
  import stbs_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req_i = '0;
  logic done_o;
  rsp_t rsp_o;

  sorted_table_binary_search_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .req_i(req_i), .done_o(done_o), .rsp_o(rsp_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [31:0] tab_key [DEPTH];
  logic [31:0] tab_val [DEPTH];
  int          held;
  rsp_t        pending_rsp [$];
  int          n_err = 0;
  int          idle_pct = 0;
  longint      cycles = 0;
  logic [31:0] used_keys [$];

  function automatic bit find_slot(logic [31:0] k, output int last);
    int lo, hi, mid;
    lo = 0;
    hi = held - 1;
    mid = -1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (tab_key[mid] == k) begin
        last = mid;
        return 1'b1;
      end
      if (tab_key[mid] < k) lo = mid + 1;
      else hi = mid - 1;
    end
    last = mid;
    return 1'b0;
  endfunction

  function automatic rsp_t table_apply(req_t r);
    rsp_t o;
    int m, pt;
    bit hit;
    o = '0;
    o.status = ST_OK;
    case (op_e'(r.op))
      OP_SEARCH: begin
        hit = find_slot(r.key, m);
        if (hit) o.found_value = tab_val[m];
        else o.status = ST_NOT_FOUND;
      end
      OP_INSERT: begin
        if (held >= DEPTH) o.status = ST_FULL;
        else if (held == 0) begin
          tab_key[0] = r.key;
          tab_val[0] = r.value;
          held = 1;
        end else begin
          void'(find_slot(r.key, m));
          if (m < 0) m = 0;
          pt = (tab_key[m] > r.key) ? m : m + 1;
          for (int i = held - 1; i >= pt; i--) begin
            tab_key[i+1] = tab_key[i];
            tab_val[i+1] = tab_val[i];
          end
          tab_key[pt] = r.key;
          tab_val[pt] = r.value;
          held++;
        end
      end
      OP_DELETE: begin
        hit = find_slot(r.key, m);
        if (hit) begin
          for (int i = m; i < held - 1; i++) begin
            tab_key[i] = tab_key[i+1];
            tab_val[i] = tab_val[i+1];
          end
          held--;
        end else o.status = ST_NOT_FOUND;
      end
      default: ;
    endcase
    o.entry_count = held[6:0];
    return o;
  endfunction

  task automatic send_op(op_e op, logic [31:0] k, logic [31:0] v);
    req_t r;
    r.op = op;
    r.key = k;
    r.value = v;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_rsp.push_back(table_apply(r));
    if (op == OP_INSERT) used_keys.push_back(k);
  endtask

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 400000) begin
      $display("status: fail");
      $finish;
    end
    if (rst_ni && done_o) begin
      if (pending_rsp.size() == 0) begin
        $error("unexpected transaction: status %0d", rsp_o.status);
        n_err++;
      end else begin
        rsp_t e;
        e = pending_rsp.pop_front();
        if (rsp_o.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, rsp_o.status);
          n_err++;
        end
        if (rsp_o.found_value !== e.found_value) begin
          $error("found_value exp %h got %h", e.found_value, rsp_o.found_value);
          n_err++;
        end
        if (rsp_o.entry_count !== e.entry_count) begin
          $error("entry_count exp %0d got %0d", e.entry_count, rsp_o.entry_count);
          n_err++;
        end
      end
    end
  end

  function automatic logic [31:0] pick_key();
    if (used_keys.size() > 0 && $urandom_range(99) < 65)
      return used_keys[$urandom_range(used_keys.size() - 1)];
    case ($urandom_range(3))
      0: return $urandom_range(15);
      1: return 32'hFFFF_FFFF - $urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    send_op(OP_SEARCH, 32'h0, 32'h0);
    send_op(OP_DELETE, 32'h5, 32'h0);
    send_op(OP_INSERT, 32'h10, 32'hAAAA_5555);
    send_op(OP_INSERT, 32'h0, 32'hFFFF_FFFF);
    send_op(OP_INSERT, 32'hFFFF_FFFF, 32'h0);
    send_op(OP_INSERT, 32'h10, 32'h5555_AAAA);
    send_op(OP_SEARCH, 32'h10, 32'h0);
    send_op(OP_SEARCH, 32'hFFFF_FFFF, 32'h0);
    send_op(OP_SEARCH, 32'h0, 32'h0);
    send_op(OP_SEARCH, 32'h11, 32'h0);
    send_op(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(OP_DELETE, 32'h10, 32'h0);
    send_op(OP_DELETE, 32'h7, 32'h0);
    send_op(OP_DELETE, 32'h0, 32'h0);
    send_op(OP_SEARCH, 32'h10, 32'h0);
  endtask

  task automatic test_fill_and_drain();
    for (int i = 0; i < DEPTH + 3; i++) send_op(OP_INSERT, $urandom_range(40), $urandom);
    for (int i = 0; i < 8; i++) send_op(OP_SEARCH, $urandom_range(40), 32'h0);
    for (int i = 0; i < 120; i++) send_op(OP_DELETE, $urandom_range(40), 32'h0);
  endtask

  task automatic test_random(int n, int pct);
    int sel;
    op_e op;
    idle_pct = pct;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (held > 56) op = (sel < 55) ? OP_DELETE : (sel < 85) ? OP_SEARCH : OP_INSERT;
      else op = (sel < 40) ? OP_INSERT : (sel < 70) ? OP_SEARCH :
                (sel < 97) ? OP_DELETE : OP_NONE;
      send_op(op, pick_key(), $urandom);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_fill_and_drain();
    test_random(450, 0);
    test_random(400, 77);
    test_random(350, 11);
    test_random(250, 0);
    start <= 1'b0;
    while (pending_rsp.size() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (n_err == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
